FILE: hdl/tgc_pkg.sv
package tgc_pkg;

  // gesture codes
  typedef enum logic [3:0] {
    G_INVALID = 4'd0,
    G_SHORT   = 4'd1,
    G_LONG    = 4'd2,
    G_HOLDX   = 4'd3,
    G_HOLDY   = 4'd4,
    G_LEFT    = 4'd5,
    G_RIGHT   = 4'd6,
    G_DOWN    = 4'd7,
    G_UP      = 4'd8,
    G_ORIGX   = 4'd9,
    G_ORIGY   = 4'd10
  } gesture_t;

  // locked slide direction
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_H    = 2'd1,
    DIR_V    = 2'd2
  } dir_t;

  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 3;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_SAME_POINT  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SHORT_PRESS = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_PRESS  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_QUICK_SLIDE = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_W    = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_H    = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE_CNT = 3'd6;

  // reset values
  localparam logic [11:0] RST_SAME_POINT  = 12'd10;
  localparam logic [15:0] RST_SHORT_PRESS = 16'd800;
  localparam logic [15:0] RST_LONG_PRESS  = 16'd2000;
  localparam logic [15:0] RST_QUICK_SLIDE = 16'd300;
  localparam logic [12:0] RST_SCREEN_W    = 13'd480;
  localparam logic [12:0] RST_SCREEN_H    = 13'd480;
  localparam logic [3:0]  RST_RELEASE_CNT = 4'd1;

  localparam logic [4:0] UP_COUNT_MAX = 5'd31;
  localparam logic [1:0] DOWN_COUNT_MAX = 2'd2;

  typedef struct packed {
    logic [11:0] same_point_threshold;
    logic [15:0] short_press_ms;
    logic [15:0] long_press_ms;
    logic [15:0] quick_slide_ms;
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic [3:0]  release_up_count;
  } cfg_t;

  typedef struct packed {
    logic     pressed;
    logic     released;
    logic     pressing;
    gesture_t gesture;
  } res_flags_t;

endpackage

FILE: hdl/tgc_state.sv
module tgc_state #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic                         is_down,
  input  logic [COORD_BITS-1:0]        sample_x,
  input  logic [COORD_BITS-1:0]        sample_y,
  input  logic [31:0]                  time_ms,
  input  tgc_pkg::cfg_t                cfg,
  output tgc_pkg::res_flags_t          flags,
  output logic signed [COORD_BITS:0]   delta_x,
  output logic signed [COORD_BITS:0]   delta_y,
  output logic [COORD_BITS-1:0]        origin_x,
  output logic [COORD_BITS-1:0]        origin_y
);

  localparam int DW   = COORD_BITS + 1;
  localparam int CMPW = ((COORD_BITS > 12) ? COORD_BITS : 12) + 1;

  logic [1:0]             down_count, down_count_next;
  logic [4:0]             up_count, up_count_next;
  logic [31:0]            start_time, start_time_next;
  logic [COORD_BITS-1:0]  first_x, first_x_next, first_y, first_y_next;
  logic [COORD_BITS-1:0]  min_x, min_x_next, max_x, max_x_next;
  logic [COORD_BITS-1:0]  min_y, min_y_next, max_y, max_y_next;
  tgc_pkg::dir_t          locked_direction, locked_direction_next;
  logic                   long_reported, long_reported_next;
  tgc_pkg::gesture_t      gesture_reg, gesture_reg_next;
  logic signed [DW-1:0]   delta_x_reg, delta_x_reg_next, delta_y_reg, delta_y_reg_next;
  logic                   pressing_reg, pressing_reg_next;
  logic                   pressed, released;

  // release side works on the stored touch
  logic [31:0]            dur_cur;
  logic [COORD_BITS-1:0]  ax_cur, ay_cur;
  logic                   moved_cur;
  // down side works on the updated touch
  logic [31:0]            dur_new;
  logic [COORD_BITS-1:0]  ax_new, ay_new;
  logic                   moved_new;
  tgc_pkg::dir_t          dir_eff;
  logic                   rel_done;

  function automatic logic [COORD_BITS-1:0] mag(input logic signed [DW-1:0] v);
    mag = v[DW-1] ? COORD_BITS'(-v) : COORD_BITS'(v);
  endfunction

  function automatic logic moved(input logic [COORD_BITS-1:0] lo_x,
                                 input logic [COORD_BITS-1:0] hi_x,
                                 input logic [COORD_BITS-1:0] lo_y,
                                 input logic [COORD_BITS-1:0] hi_y,
                                 input logic [11:0] thr);
    moved = (CMPW'(hi_x - lo_x) >= CMPW'(thr)) || (CMPW'(hi_y - lo_y) >= CMPW'(thr));
  endfunction

  assign dur_cur   = time_ms - start_time;
  assign ax_cur    = mag(delta_x_reg);
  assign ay_cur    = mag(delta_y_reg);
  assign moved_cur = moved(min_x, max_x, min_y, max_y, cfg.same_point_threshold);

  always_comb begin
    down_count_next       = down_count;
    up_count_next         = up_count;
    start_time_next       = start_time;
    first_x_next          = first_x;
    first_y_next          = first_y;
    min_x_next            = min_x;
    max_x_next            = max_x;
    min_y_next            = min_y;
    max_y_next            = max_y;
    locked_direction_next = locked_direction;
    long_reported_next    = long_reported;
    gesture_reg_next      = gesture_reg;
    delta_x_reg_next      = delta_x_reg;
    delta_y_reg_next      = delta_y_reg;
    pressing_reg_next     = pressing_reg;
    pressed               = 1'b0;
    released              = 1'b0;
    dur_new               = '0;
    ax_new                = '0;
    ay_new                = '0;
    moved_new             = 1'b0;
    dir_eff               = locked_direction;
    rel_done              = 1'b0;

    if (is_down) begin
      up_count_next = '0;
      if (down_count != tgc_pkg::DOWN_COUNT_MAX) begin
        down_count_next = down_count + 2'd1;
      end
      if (down_count == 2'd0) begin
        // first sample of a touch
        long_reported_next    = 1'b0;
        pressed               = 1'b1;
        pressing_reg_next     = 1'b1;
        start_time_next       = time_ms;
        first_x_next          = sample_x;
        min_x_next            = sample_x;
        max_x_next            = sample_x;
        first_y_next          = sample_y;
        min_y_next            = sample_y;
        max_y_next            = sample_y;
        gesture_reg_next      = tgc_pkg::G_INVALID;
        locked_direction_next = tgc_pkg::DIR_NONE;
      end else begin
        if (sample_x < min_x) min_x_next = sample_x;
        if (sample_x > max_x) max_x_next = sample_x;
        if (sample_y < min_y) min_y_next = sample_y;
        if (sample_y > max_y) max_y_next = sample_y;
      end
      delta_x_reg_next = $signed({1'b0, sample_x}) - $signed({1'b0, first_x_next});
      delta_y_reg_next = $signed({1'b0, sample_y}) - $signed({1'b0, first_y_next});

      dur_new   = time_ms - start_time_next;
      ax_new    = mag(delta_x_reg_next);
      ay_new    = mag(delta_y_reg_next);
      moved_new = moved(min_x_next, max_x_next, min_y_next, max_y_next,
                        cfg.same_point_threshold);

      if (moved_new) begin
        // first move locks the direction
        if (locked_direction_next == tgc_pkg::DIR_NONE) begin
          dir_eff = (ax_new >= ay_new) ? tgc_pkg::DIR_H : tgc_pkg::DIR_V;
        end else begin
          dir_eff = locked_direction_next;
        end
        locked_direction_next = dir_eff;
        gesture_reg_next = (dir_eff == tgc_pkg::DIR_H) ? tgc_pkg::G_HOLDX : tgc_pkg::G_HOLDY;
      end else if (dur_new > 32'(cfg.long_press_ms) && !long_reported_next) begin
        long_reported_next = 1'b1;
        gesture_reg_next   = tgc_pkg::G_LONG;
      end
    end else begin
      if (up_count != tgc_pkg::UP_COUNT_MAX) begin
        up_count_next = up_count + 5'd1;
      end
      if (down_count == 2'd0) begin
        gesture_reg_next = tgc_pkg::G_INVALID;
      end
      if (up_count_next == {1'b0, cfg.release_up_count} && down_count != 2'd0) begin
        released          = 1'b1;
        pressing_reg_next = 1'b0;
        down_count_next   = '0;
        if (!moved_cur && dur_cur <= 32'(cfg.short_press_ms)) begin
          gesture_reg_next = tgc_pkg::G_SHORT;
          rel_done         = 1'b1;
        end else if (dur_cur < 32'(cfg.quick_slide_ms)) begin
          if (ax_cur >= ay_cur) begin
            if (delta_x_reg < 0) begin
              gesture_reg_next = tgc_pkg::G_LEFT;
              rel_done         = 1'b1;
            end else if (delta_x_reg > 0) begin
              gesture_reg_next = tgc_pkg::G_RIGHT;
              rel_done         = 1'b1;
            end
          end else begin
            if (delta_y_reg > 0) begin
              gesture_reg_next = tgc_pkg::G_DOWN;
              rel_done         = 1'b1;
            end else if (delta_y_reg < 0) begin
              gesture_reg_next = tgc_pkg::G_UP;
              rel_done         = 1'b1;
            end
          end
        end
        // slow slide: far enough or back to origin
        if (!rel_done) begin
          if (gesture_reg == tgc_pkg::G_HOLDX) begin
            if (CMPW'(ax_cur) > CMPW'(cfg.screen_width[12:1])) begin
              gesture_reg_next = (delta_x_reg < 0) ? tgc_pkg::G_LEFT : tgc_pkg::G_RIGHT;
            end else begin
              gesture_reg_next = tgc_pkg::G_ORIGX;
            end
          end else if (gesture_reg == tgc_pkg::G_HOLDY) begin
            if (CMPW'(ay_cur) > CMPW'(cfg.screen_height[12:1])) begin
              gesture_reg_next = (delta_y_reg > 0) ? tgc_pkg::G_DOWN : tgc_pkg::G_UP;
            end else begin
              gesture_reg_next = tgc_pkg::G_ORIGY;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down_count       <= '0;
      up_count         <= '0;
      start_time       <= '0;
      first_x          <= '0;
      first_y          <= '0;
      min_x            <= '0;
      max_x            <= '0;
      min_y            <= '0;
      max_y            <= '0;
      locked_direction <= tgc_pkg::DIR_NONE;
      long_reported    <= 1'b0;
      gesture_reg      <= tgc_pkg::G_INVALID;
      delta_x_reg      <= '0;
      delta_y_reg      <= '0;
      pressing_reg     <= 1'b0;
    end else if (advance) begin
      down_count       <= down_count_next;
      up_count         <= up_count_next;
      start_time       <= start_time_next;
      first_x          <= first_x_next;
      first_y          <= first_y_next;
      min_x            <= min_x_next;
      max_x            <= max_x_next;
      min_y            <= min_y_next;
      max_y            <= max_y_next;
      locked_direction <= locked_direction_next;
      long_reported    <= long_reported_next;
      gesture_reg      <= gesture_reg_next;
      delta_x_reg      <= delta_x_reg_next;
      delta_y_reg      <= delta_y_reg_next;
      pressing_reg     <= pressing_reg_next;
    end
  end

  assign flags.pressed  = pressed;
  assign flags.released = released;
  assign flags.pressing = pressing_reg_next;
  assign flags.gesture  = gesture_reg_next;
  assign delta_x        = delta_x_reg_next;
  assign delta_y        = delta_y_reg_next;
  assign origin_x       = first_x_next;
  assign origin_y       = first_y_next;

endmodule

FILE: hdl/touch_gesture_classifier.sv
// Channel  Handshake           Payload
// -------  ------------------  ----------------------------------------------------
// in       in_valid/in_ready   is_down, sample_x, sample_y, time_ms
// out      out_valid/out_ready pressed_pulse, released_pulse, pressing, gesture,
//                              delta_x, delta_y, origin_x, origin_y
// cfg      cfg_write           cfg_index, cfg_data (write only, no wait)
//
// One result item per sample item, one item per cycle sustained while out_ready is high.
// The sample lands in the input register, then the classifier logic and
// touch state update feed the result register.
// A held result keeps any sample in the input register; an empty input register
// takes one more sample, then in_ready drops until out_ready returns.
// rst is synchronous: touch state cleared, config back to defaults, both stages empty.
module touch_gesture_classifier #(
  parameter int COORD_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // sample channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   is_down,
  input  logic [COORD_BITS-1:0]                  sample_x,
  input  logic [COORD_BITS-1:0]                  sample_y,
  input  logic [31:0]                            time_ms,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   pressed_pulse,
  output logic                                   released_pulse,
  output logic                                   pressing,
  output logic [3:0]                             gesture,
  output logic signed [COORD_BITS:0]             delta_x,
  output logic signed [COORD_BITS:0]             delta_y,
  output logic [COORD_BITS-1:0]                  origin_x,
  output logic [COORD_BITS-1:0]                  origin_y,
  // config port
  input  logic                                   cfg_write,
  input  logic [tgc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [tgc_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  tgc_pkg::cfg_t cfg;

  // input stage
  logic                  s1_valid;
  logic                  s1_down;
  logic [COORD_BITS-1:0] s1_x, s1_y;
  logic [31:0]           s1_t;
  logic                  advance;

  // classifier result for the sample in the input stage
  tgc_pkg::res_flags_t          res_flags;
  logic signed [COORD_BITS:0]   res_dx, res_dy;
  logic [COORD_BITS-1:0]        res_ox, res_oy;

  // result register
  tgc_pkg::res_flags_t out_flags;

  // sample moves on when the result register is empty or being drained
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.same_point_threshold <= tgc_pkg::RST_SAME_POINT;
      cfg.short_press_ms       <= tgc_pkg::RST_SHORT_PRESS;
      cfg.long_press_ms        <= tgc_pkg::RST_LONG_PRESS;
      cfg.quick_slide_ms       <= tgc_pkg::RST_QUICK_SLIDE;
      cfg.screen_width         <= tgc_pkg::RST_SCREEN_W;
      cfg.screen_height        <= tgc_pkg::RST_SCREEN_H;
      cfg.release_up_count     <= tgc_pkg::RST_RELEASE_CNT;
    end else if (cfg_write) begin
      case (cfg_index)
        tgc_pkg::REG_SAME_POINT:  cfg.same_point_threshold <= cfg_data[11:0];
        tgc_pkg::REG_SHORT_PRESS: cfg.short_press_ms       <= cfg_data;
        tgc_pkg::REG_LONG_PRESS:  cfg.long_press_ms        <= cfg_data;
        tgc_pkg::REG_QUICK_SLIDE: cfg.quick_slide_ms       <= cfg_data;
        tgc_pkg::REG_SCREEN_W:    cfg.screen_width         <= cfg_data[12:0];
        tgc_pkg::REG_SCREEN_H:    cfg.screen_height        <= cfg_data[12:0];
        tgc_pkg::REG_RELEASE_CNT: cfg.release_up_count     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_down <= is_down;
      s1_x    <= sample_x;
      s1_y    <= sample_y;
      s1_t    <= time_ms;
    end
  end

  tgc_state #(
    .COORD_BITS(COORD_BITS)
  ) u_state (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .is_down  (s1_down),
    .sample_x (s1_x),
    .sample_y (s1_y),
    .time_ms  (s1_t),
    .cfg      (cfg),
    .flags    (res_flags),
    .delta_x  (res_dx),
    .delta_y  (res_dy),
    .origin_x (res_ox),
    .origin_y (res_oy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_flags <= res_flags;
      delta_x   <= res_dx;
      delta_y   <= res_dy;
      origin_x  <= res_ox;
      origin_y  <= res_oy;
    end
  end

  assign pressed_pulse  = out_flags.pressed;
  assign released_pulse = out_flags.released;
  assign pressing       = out_flags.pressing;
  assign gesture        = out_flags.gesture;

  // a touch cannot start and end on the same sample
  a_pulses_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(pressed_pulse && released_pulse))
    else $error("pressed and released pulses together");

  // pulses agree with the pressing level
  a_pulse_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!pressed_pulse || pressing) && (!released_pulse || !pressing))
    else $error("pulse disagrees with pressing level");

  // a release always resolves a hold gesture
  a_release_no_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && released_pulse) |->
      (gesture != tgc_pkg::G_HOLDX) && (gesture != tgc_pkg::G_HOLDY))
    else $error("hold gesture left after release");

  // the input stage only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !in_ready) |-> (out_valid && !out_ready))
    else $error("input stage stalled without output backpressure");

endmodule
